// File: rtl/aid_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the attitude indicator drawer.
// No dependencies; imported by the controller, the datapath and the top level.
package aid_pkg;

    localparam int SLOT_W    = 4;
    localparam int NUM_SLOTS = 14;
    localparam int NUM_LINES = 5;
    localparam int CFG_IDX_W = 4;
    localparam int CALC_CYCLES = 7;
    localparam int CNT_W     = 3;

    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    // Write slots in emission order
    localparam slot_t SLOT_PITCH_BLANK_L = 4'd0;
    localparam slot_t SLOT_PITCH_BLANK_R = 4'd1;
    localparam slot_t SLOT_PITCH_LINE_L  = 4'd2;
    localparam slot_t SLOT_PITCH_LINE_R  = 4'd3;
    localparam slot_t SLOT_ROLL1_BLANK   = 4'd4;
    localparam slot_t SLOT_ROLL1_LINE    = 4'd5;
    localparam slot_t SLOT_ROLL2_BLANK   = 4'd6;
    localparam slot_t SLOT_ROLL2_LINE    = 4'd7;
    localparam slot_t SLOT_ROLL3_BLANK   = 4'd8;
    localparam slot_t SLOT_ROLL3_LINE    = 4'd9;
    localparam slot_t SLOT_ROLL4_BLANK   = 4'd10;
    localparam slot_t SLOT_ROLL4_LINE    = 4'd11;
    localparam slot_t SLOT_RETICLE_0     = 4'd12;
    localparam slot_t SLOT_RETICLE_1     = 4'd13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETICLE = 4'd3;

    localparam logic [7:0] CENTER_RESET  = 8'd126;
    localparam logic [7:0] TOP_RESET     = 8'd54;
    localparam logic [7:0] BOTTOM_RESET  = 8'd197;
    localparam logic [3:0] RETICLE_RESET = 4'd7;
    localparam logic [3:0] MODE_RESET    = 4'd9;

    localparam logic [7:0] GLYPH_BASE  = 8'h80;
    localparam logic [4:0] CELL_PIXELS = 5'd18;
    localparam logic [4:0] PITCH_COL_L = 5'd7;
    localparam logic [4:0] PITCH_COL_R = 5'd22;
    localparam logic [4:0] MARK_COL    = 5'd14;
    localparam logic [4:0] ROLL_COL [4] = '{5'd10, 5'd12, 5'd17, 5'd19};

    localparam int ROW_SW  = 20;
    localparam int PD_W    = 24;
    localparam int PNUM_W  = 42;
    localparam int NEAR_W  = 21;
    localparam int FAR_W   = 23;
    localparam logic [17:0] INV_QTR_PI = 18'd83443;
    localparam logic [5:0]  NEAR_MUL   = 6'd42;
    localparam logic [8:0]  FAR_MUL    = 9'd378;
    localparam logic [15:0] DIV5_MUL   = 16'd52429;
    localparam int DIV5_SHIFT = 18;

    typedef struct packed {
        logic  capture;
        logic  load_out;
        logic  commit;
        slot_t slot;
    } cmd_t;

    typedef struct packed {
        slot_mask_t slot_mask;
    } status_t;

    function automatic logic [3:0] cell_row(input logic [7:0] px);
        logic [15:0] prod;
        prod = 16'(px) * 16'd57;
        return prod[13:10];
    endfunction

    function automatic logic [7:0] cell_glyph(input logic [7:0] px);
        logic [3:0] q;
        logic [8:0] base;
        q    = cell_row(px);
        base = 9'(q) * 9'(CELL_PIXELS);
        return GLYPH_BASE + 8'(9'(px) - base);
    endfunction

endpackage

// File: rtl/aid_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, row arithmetic pipeline, line state and
// result register. Depends on aid_pkg; driven by aid_ctrl commands.
module aid_datapath #(
    parameter int ANGLE_FRAC_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [aid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic [14:0]                   roll_angle,
    input  logic [14:0]                   pitch_angle,
    input  logic [1:0]                    flight_mode,
    input  logic                          force_redraw,
    input  aid_pkg::cmd_t                 cmd,
    output aid_pkg::status_t              status,
    output logic [3:0]                    char_row,
    output logic [4:0]                    char_col,
    output logic [7:0]                    glyph,
    output logic                          blank
);
    import aid_pkg::*;

    localparam int PITCH_SHIFT = ANGLE_FRAC_BITS + 16;
    localparam int POFF_W      = 26 - ANGLE_FRAC_BITS;
    localparam int NEAR_Q_W    = NEAR_W - ANGLE_FRAC_BITS;
    localparam int FAR_Q1_W    = FAR_W - ANGLE_FRAC_BITS;
    localparam int FAR_PROD_W  = FAR_Q1_W + 16;
    localparam int FAR_Q_W     = FAR_PROD_W - DIV5_SHIFT;
    localparam logic [PNUM_W-1:0] PITCH_BIAS = (42'd1 << PITCH_SHIFT) - 42'd1;

    function automatic logic [7:0] clamp_row(input logic signed [ROW_SW-1:0] x,
                                             input logic [7:0] lo,
                                             input logic [7:0] hi);
        logic signed [ROW_SW-1:0] lo_x;
        logic signed [ROW_SW-1:0] hi_x;
        lo_x = $signed({12'd0, lo});
        hi_x = $signed({12'd0, hi});
        if (x < lo_x)
            return lo;
        else if (x > hi_x)
            return hi;
        else
            return x[7:0];
    endfunction

    // Configuration and drawn state
    logic [7:0] center_reg, top_reg, bottom_reg;
    logic [3:0] reticle_reg;
    logic [3:0] line_rows_reg [NUM_LINES];
    logic [3:0] shown_mode_reg;

    // Captured request
    logic signed [14:0] roll_reg, pitch_reg;
    logic [1:0]         mode_reg;
    logic               force_reg;

    // Pipeline
    logic signed [PD_W-1:0]     s1_pd_reg, s1_pd_next;
    logic [NEAR_W-1:0]          s1_near_reg, s1_near_next;
    logic [FAR_W-1:0]           s1_far_reg, s1_far_next;
    logic                       s1_rneg_reg;
    logic signed [PNUM_W-1:0]   s2_pnum_reg, s2_pnum_next;
    logic [NEAR_Q_W-1:0]        s2_near_reg, s2_near_next;
    logic [FAR_Q1_W-1:0]        s2_far_reg, s2_far_next;
    logic                       s2_rneg_reg;
    logic signed [POFF_W-1:0]   s3_poff_reg, s3_poff_next;
    logic signed [ROW_SW-1:0]   s3_noff_reg, s3_noff_next;
    logic signed [ROW_SW-1:0]   s3_foff_reg, s3_foff_next;
    logic [7:0]                 s4_row0_reg, s4_row3_reg, s4_row4_reg;
    logic [7:0]                 s5_row_reg [NUM_LINES];
    logic [3:0]                 s6_crow_reg [NUM_LINES];
    logic [7:0]                 s6_glyph_reg [NUM_LINES];

    // Result register
    logic [3:0] out_row_reg, out_row_next;
    logic [4:0] out_col_reg, out_col_next;
    logic [7:0] out_glyph_reg, out_glyph_next;
    logic       out_blank_reg, out_blank_next;

    logic signed [8:0]        diff;
    logic [14:0]              rmag;
    logic signed [PD_W-1:0]   pitch_x, diff_x;
    logic signed [PNUM_W-1:0] pd_x, psum, psh;
    logic [NEAR_W-1:0]        near_sh;
    logic [FAR_W-1:0]         far_sh;
    logic [FAR_PROD_W-1:0]    far_prod;
    logic [FAR_Q_W-1:0]       far_q;
    logic [ROW_SW-1:0]        near_ext, far_ext;
    logic signed [ROW_SW-1:0] cx, x0, x3, x4, x1, x2;
    logic                     reticle_due;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg  <= CENTER_RESET;
            top_reg     <= TOP_RESET;
            bottom_reg  <= BOTTOM_RESET;
            reticle_reg <= RETICLE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_CENTER)  center_reg  <= cfg_data;
            if (cfg_index == CFG_TOP)     top_reg     <= cfg_data;
            if (cfg_index == CFG_BOTTOM)  bottom_reg  <= cfg_data;
            if (cfg_index == CFG_RETICLE) reticle_reg <= cfg_data[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LINES; i++)
                line_rows_reg[i] <= 4'd0;
            shown_mode_reg <= MODE_RESET;
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < NUM_LINES; i++)
                line_rows_reg[i] <= s6_crow_reg[i];
            shown_mode_reg <= {2'b00, mode_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            roll_reg  <= $signed(roll_angle);
            pitch_reg <= $signed(pitch_angle);
            mode_reg  <= flight_mode;
            force_reg <= force_redraw;
        end
    end

    always_comb
    begin
        // Stage 1: first products
        diff         = $signed({1'b0, center_reg}) - $signed({1'b0, top_reg});
        pitch_x      = PD_W'(pitch_reg);
        diff_x       = PD_W'(diff);
        s1_pd_next   = pitch_x * diff_x;
        rmag         = roll_reg[14] ? (~roll_reg + 15'd1) : roll_reg;
        s1_near_next = NEAR_W'(rmag) * NEAR_W'(NEAR_MUL);
        s1_far_next  = FAR_W'(rmag) * FAR_W'(FAR_MUL);

        // Stage 2: pitch scale, roll fraction drop
        pd_x         = PNUM_W'(s1_pd_reg);
        s2_pnum_next = pd_x * $signed(PNUM_W'(INV_QTR_PI));
        near_sh      = s1_near_reg >> ANGLE_FRAC_BITS;
        far_sh       = s1_far_reg >> ANGLE_FRAC_BITS;
        s2_near_next = near_sh[NEAR_Q_W-1:0];
        s2_far_next  = far_sh[FAR_Q1_W-1:0];

        // Stage 3: truncating shift, divide by five, apply sign
        psum         = s2_pnum_reg + (s2_pnum_reg[PNUM_W-1] ? $signed(PITCH_BIAS) : '0);
        psh          = psum >>> PITCH_SHIFT;
        s3_poff_next = psh[POFF_W-1:0];
        far_prod     = FAR_PROD_W'(s2_far_reg) * FAR_PROD_W'(DIV5_MUL);
        far_q        = far_prod[FAR_PROD_W-1:DIV5_SHIFT];
        near_ext     = ROW_SW'(s2_near_reg);
        far_ext      = ROW_SW'(far_q);
        s3_noff_next = s2_rneg_reg ? -near_ext : near_ext;
        s3_foff_next = s2_rneg_reg ? -far_ext : far_ext;

        // Stages 4 and 5: row sums
        cx = $signed({12'd0, center_reg});
        x0 = cx + ROW_SW'(s3_poff_reg);
        x3 = cx - s3_noff_reg;
        x4 = cx - s3_foff_reg;
        x1 = (cx <<< 1) - $signed({12'd0, s4_row4_reg});
        x2 = (cx <<< 1) - $signed({12'd0, s4_row3_reg});
    end

    always_ff @(posedge clk)
    begin
        s1_pd_reg   <= s1_pd_next;
        s1_near_reg <= s1_near_next;
        s1_far_reg  <= s1_far_next;
        s1_rneg_reg <= roll_reg[14];
        s2_pnum_reg <= s2_pnum_next;
        s2_near_reg <= s2_near_next;
        s2_far_reg  <= s2_far_next;
        s2_rneg_reg <= s1_rneg_reg;
        s3_poff_reg <= s3_poff_next;
        s3_noff_reg <= s3_noff_next;
        s3_foff_reg <= s3_foff_next;
        s4_row0_reg <= clamp_row(x0, top_reg, bottom_reg);
        s4_row3_reg <= clamp_row(x3, top_reg, bottom_reg);
        s4_row4_reg <= clamp_row(x4, top_reg, bottom_reg);
        s5_row_reg[0] <= s4_row0_reg;
        s5_row_reg[1] <= clamp_row(x1, top_reg, bottom_reg);
        s5_row_reg[2] <= clamp_row(x2, top_reg, bottom_reg);
        s5_row_reg[3] <= s4_row3_reg;
        s5_row_reg[4] <= s4_row4_reg;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            s6_crow_reg[i]  <= cell_row(s5_row_reg[i]);
            s6_glyph_reg[i] <= cell_glyph(s5_row_reg[i]);
        end
    end

    assign reticle_due = (shown_mode_reg != {2'b00, mode_reg}) || force_reg;

    always_comb
    begin
        status.slot_mask = '0;
        status.slot_mask[SLOT_PITCH_BLANK_L] = line_rows_reg[0] != s6_crow_reg[0];
        status.slot_mask[SLOT_PITCH_BLANK_R] = line_rows_reg[0] != s6_crow_reg[0];
        status.slot_mask[SLOT_PITCH_LINE_L]  = 1'b1;
        status.slot_mask[SLOT_PITCH_LINE_R]  = 1'b1;
        status.slot_mask[SLOT_ROLL1_BLANK]   = line_rows_reg[1] != s6_crow_reg[1];
        status.slot_mask[SLOT_ROLL1_LINE]    = 1'b1;
        status.slot_mask[SLOT_ROLL2_BLANK]   = line_rows_reg[2] != s6_crow_reg[2];
        status.slot_mask[SLOT_ROLL2_LINE]    = 1'b1;
        status.slot_mask[SLOT_ROLL3_BLANK]   = line_rows_reg[3] != s6_crow_reg[3];
        status.slot_mask[SLOT_ROLL3_LINE]    = 1'b1;
        status.slot_mask[SLOT_ROLL4_BLANK]   = line_rows_reg[4] != s6_crow_reg[4];
        status.slot_mask[SLOT_ROLL4_LINE]    = 1'b1;
        status.slot_mask[SLOT_RETICLE_0]     = reticle_due;
        status.slot_mask[SLOT_RETICLE_1]     = reticle_due;
    end

    always_comb
    begin
        out_row_next   = s6_crow_reg[0];
        out_col_next   = PITCH_COL_L;
        out_glyph_next = 8'd0;
        out_blank_next = 1'b0;
        unique case (cmd.slot)
            SLOT_PITCH_BLANK_L:
            begin
                out_row_next   = line_rows_reg[0];
                out_blank_next = 1'b1;
            end
            SLOT_PITCH_BLANK_R:
            begin
                out_row_next   = line_rows_reg[0];
                out_col_next   = PITCH_COL_R;
                out_blank_next = 1'b1;
            end
            SLOT_PITCH_LINE_L:
                out_glyph_next = s6_glyph_reg[0];
            SLOT_PITCH_LINE_R:
            begin
                out_col_next   = PITCH_COL_R;
                out_glyph_next = s6_glyph_reg[0];
            end
            SLOT_ROLL1_BLANK, SLOT_ROLL2_BLANK, SLOT_ROLL3_BLANK, SLOT_ROLL4_BLANK,
            SLOT_ROLL1_LINE, SLOT_ROLL2_LINE, SLOT_ROLL3_LINE, SLOT_ROLL4_LINE:
            begin
                // Line index 1..4 is slot bits [3:1] minus one, blank on even slots
                out_col_next = ROLL_COL[2'(cmd.slot[2:1] - 2'd2)];
                if (!cmd.slot[0])
                begin
                    out_row_next   = line_rows_reg[3'(cmd.slot[3:1]) - 3'd1];
                    out_blank_next = 1'b1;
                end
                else
                begin
                    out_row_next   = s6_crow_reg[3'(cmd.slot[3:1]) - 3'd1];
                    out_glyph_next = s6_glyph_reg[3'(cmd.slot[3:1]) - 3'd1];
                end
            end
            SLOT_RETICLE_0:
            begin
                out_row_next   = reticle_reg;
                out_col_next   = MARK_COL;
                out_glyph_next = {5'd0, mode_reg, 1'b1};
            end
            SLOT_RETICLE_1:
            begin
                out_row_next   = reticle_reg;
                out_col_next   = MARK_COL + 5'd1;
                out_glyph_next = {5'd0, mode_reg, 1'b1} + 8'd1;
            end
            default:
            begin
                out_row_next   = 4'd0;
                out_col_next   = 5'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            out_glyph_reg <= out_glyph_next;
            out_blank_reg <= out_blank_next;
        end
    end

    assign char_row = out_row_reg;
    assign char_col = out_col_reg;
    assign glyph    = out_glyph_reg;
    assign blank    = out_blank_reg;

endmodule

// File: rtl/aid_ctrl.sv
`timescale 1ns / 1ps
// Controller: request handshake, arithmetic wait count and write slot sequencing.
// Depends on aid_pkg; drives aid_datapath through cmd_t.
module aid_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             last,
    input  aid_pkg::status_t status,
    output aid_pkg::cmd_t    cmd
);
    import aid_pkg::*;

    localparam logic [CNT_W-1:0] CALC_LAST = CNT_W'(CALC_CYCLES - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    slot_mask_t       mask_reg, mask_next;
    logic             out_valid_reg, out_valid_next;
    logic             last_reg, last_next;
    slot_mask_t       low_bit, mask_rest;
    slot_t            low_slot;
    logic             take;

    always_comb
    begin
        low_bit  = mask_reg & (~mask_reg + slot_mask_t'(1));
        low_slot = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (low_bit[i])
                low_slot = SLOT_W'(i);
        mask_rest = mask_reg & ~low_bit;
    end

    assign take = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg;
        last_next      = last_reg;
        in_ready       = 1'b0;
        cmd.capture    = 1'b0;
        cmd.load_out   = 1'b0;
        cmd.commit     = 1'b0;
        cmd.slot       = low_slot;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CALC_LAST)
                begin
                    mask_next  = status.slot_mask;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (take)
                begin
                    if (out_valid_reg && last_reg)
                    begin
                        cmd.commit     = 1'b1;
                        out_valid_next = 1'b0;
                        last_next      = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        cmd.load_out   = 1'b1;
                        out_valid_next = 1'b1;
                        mask_next      = mask_rest;
                        last_next      = (mask_rest == '0);
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == ST_EMIT)
        else $error("result shown outside emit phase");

    a_commit_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> out_valid_reg && out_ready && last_reg)
        else $error("line state committed before final write taken");

    a_last_drains_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> mask_reg == '0)
        else $error("final write flagged with slots pending");

    a_mask_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CALC && cnt_reg == CALC_LAST |=> mask_reg != '0)
        else $error("empty slot mask after arithmetic");
`endif

endmodule

// File: rtl/attitude_indicator_drawer_top.sv
`timescale 1ns / 1ps
// Attitude indicator drawer: places pitch and roll line glyphs and the mode reticle.
// The first write follows the row math pipeline after a request is accepted.
// Throughput: one request at a time, n = 6..14 writes per request,
// one write per cycle while out_ready is high; the serial write slots set the rate.
// Reset (rst_n low, async) restores register defaults, clears line rows, forces reticle.
// Depends on aid_pkg, aid_ctrl and aid_datapath.
module attitude_indicator_drawer_top #(
    parameter int ANGLE_FRAC_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [aid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [14:0]                   roll_angle,
    input  logic [14:0]                   pitch_angle,
    input  logic [1:0]                    flight_mode,
    input  logic                          force_redraw,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    char_row,
    output logic [4:0]                    char_col,
    output logic [7:0]                    glyph,
    output logic                          blank,
    output logic                          last
);
    import aid_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    aid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .last      (last),
        .status    (status),
        .cmd       (cmd)
    );

    aid_datapath #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .roll_angle   (roll_angle),
        .pitch_angle  (pitch_angle),
        .flight_mode  (flight_mode),
        .force_redraw (force_redraw),
        .cmd          (cmd),
        .status       (status),
        .char_row     (char_row),
        .char_col     (char_col),
        .glyph        (glyph),
        .blank        (blank)
    );

endmodule
